[rtl/efr_pkg.sv]
// Package: constants, event codes and output types for the escaped frame receiver.
`timescale 1ns / 1ps

package efr_pkg;

    localparam logic [7:0] MAX_POSITION = 8'd110;
    localparam logic [7:0] START_MARK   = 8'h7E;
    localparam logic [7:0] ESC_MARK     = 8'h7D;
    localparam logic [7:0] ESC_FLIP     = 8'h20;
    localparam logic [7:0] SUM_GOOD     = 8'hFF;
    localparam logic [7:0] POS_LAST     = 8'hFF;
    localparam logic [7:0] POS_PAYLOAD  = 8'd4;
    localparam logic [16:0] END_OFFSET  = 17'd3;

    localparam int TDATA_W = 40;
    localparam int PADDR_W = 3;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_DATA   = 3'd1,
        EV_OK     = 3'd2,
        EV_BADSUM = 3'd3,
        EV_LONG   = 3'd4,
        EV_START  = 3'd5
    } event_t;

    typedef enum logic [0:0] {
        REG_CHECK_START = 1'b0
    } reg_index_t;

    typedef struct packed {
        logic [1:0] pad;
        logic [7:0] checksum_byte;
        logic [6:0] frame_length;
        logic [7:0] api_id;
        logic [6:0] payload_index;
        logic [7:0] payload_byte;
    } result_data_t;

endpackage

[rtl/escaped_frame_receiver.sv]
// Top level: escaped API frame receiver with checksum check and payload streaming.
//
// Usage:
//   s_ channel: one raw serial byte per transaction (s_tdata[7:0] = rx_byte).
//   m_ channel: exactly one result per input transaction. m_tuser holds the
//     event code (0 nothing, 1 payload byte, 2 frame ok, 3 bad checksum,
//     4 too long, 5 unexpected start); m_tdata holds payload byte, payload
//     index, API id, frame length and checksum byte.
//   APB port: register 0 (address 0), bit 0 = check_unexpected_start.
//     Write only while the block is idle.
// Output: the result is registered and valid in the cycle after the input transaction.
// Throughput: 1 byte per cycle while the output register is empty or m_tready is high;
//   the parser state, the check bit and the single output register are the only storage.
// Reset: parser returns to hunting for a start byte, check_unexpected_start
//   is set, the output register is emptied.
// Stall: when m_tready is low with a result held, s_tready drops until the
//   result is taken; nothing is dropped or repeated.
`timescale 1ns / 1ps

module escaped_frame_receiver
    import efr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // tdata: [7:0] rx_byte
    input  logic [7:0]           s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata: [7:0] payload_byte, [14:8] payload_index, [22:15] api_id,
    //        [29:23] frame_length, [37:30] checksum_byte, [39:38] zero
    output logic [TDATA_W-1:0]   m_tdata,
    // tuser: [2:0] event_res
    output logic [2:0]           m_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic         check_start_reg;
    logic [7:0]   position_reg, position_next;
    logic [7:0]   length_high_reg, length_high_next;
    logic [7:0]   length_low_reg, length_low_next;
    logic [7:0]   frame_id_reg, frame_id_next;
    logic [7:0]   sum_reg, sum_next;
    logic         esc_reg, esc_next;
    logic         over_reg, over_next;
    logic         m_valid_reg;
    result_data_t data_reg, data_next;
    event_t       event_reg, event_next;

    logic         accept;
    logic [7:0]   pos;
    logic [7:0]   sum_cur;
    logic         esc_cur;
    logic [7:0]   b;
    logic [7:0]   sum_add;
    logic [16:0]  end_pos;
    logic [7:0]   pos_rel;
    logic         do_parse;

    assign pready   = 1'b1;
    assign s_tready = aresetn & (~m_valid_reg | m_tready);
    assign accept   = s_tvalid & s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = event_reg;

    always_comb begin
        prdata = '0;
        if (paddr[PADDR_W-1] == REG_CHECK_START) begin
            prdata[0] = check_start_reg;
        end
    end

    // a finished or failed frame restarts the parser on the next byte
    assign pos     = over_reg ? 8'd0 : position_reg;
    assign sum_cur = over_reg ? 8'd0 : sum_reg;
    assign esc_cur = over_reg ? 1'b0 : esc_reg;
    assign end_pos = {1'b0, length_high_reg, length_low_reg} + END_OFFSET;
    assign pos_rel = pos - POS_PAYLOAD;

    always_comb begin
        position_next    = pos;
        length_high_next = length_high_reg;
        length_low_next  = length_low_reg;
        frame_id_next    = frame_id_reg;
        sum_next         = sum_cur;
        esc_next         = esc_cur;
        over_next        = 1'b0;
        event_next       = EV_NONE;
        data_next        = '0;
        b                = s_tdata;
        sum_add          = sum_cur;
        do_parse         = 1'b0;

        if (pos != 8'd0 && s_tdata == START_MARK && check_start_reg) begin
            over_next         = 1'b1;
            event_next        = EV_START;
            data_next.api_id  = frame_id_reg;
        end else if (esc_cur) begin
            b        = s_tdata ^ ESC_FLIP;
            esc_next = 1'b0;
            do_parse = 1'b1;
        end else if (pos != 8'd0 && s_tdata == ESC_MARK) begin
            esc_next = 1'b1;
        end else begin
            do_parse = 1'b1;
        end

        if (do_parse) begin
            if (pos >= 8'd3) begin
                sum_add = sum_cur + b;
            end
            sum_next = sum_add;
            case (pos)
                8'd0: begin
                    if (b == START_MARK) begin
                        position_next = 8'd1;
                    end
                end
                8'd1: begin
                    length_high_next = b;
                    position_next    = 8'd2;
                end
                8'd2: begin
                    length_low_next = b;
                    position_next   = 8'd3;
                end
                8'd3: begin
                    frame_id_next = b;
                    position_next = 8'd4;
                end
                default: begin
                    data_next.api_id = frame_id_reg;
                    if (pos > MAX_POSITION) begin
                        over_next  = 1'b1;
                        event_next = EV_LONG;
                    end else if ({9'd0, pos} == end_pos) begin
                        data_next.frame_length = pos_rel[6:0];
                        if (sum_add == SUM_GOOD) begin
                            event_next              = EV_OK;
                            data_next.checksum_byte = b;
                        end else begin
                            event_next = EV_BADSUM;
                        end
                        position_next = 8'd0;
                        sum_next      = 8'd0;
                        over_next     = 1'b1;
                    end else if (pos == POS_LAST) begin
                        over_next  = 1'b1;
                        event_next = EV_LONG;
                    end else begin
                        event_next              = EV_DATA;
                        data_next.payload_byte  = b;
                        data_next.payload_index = pos_rel[6:0];
                        position_next           = pos + 8'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_start_reg <= 1'b1;
            position_reg    <= '0;
            length_high_reg <= '0;
            length_low_reg  <= '0;
            frame_id_reg    <= '0;
            sum_reg         <= '0;
            esc_reg         <= 1'b0;
            over_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
            event_reg       <= EV_NONE;
        end else begin
            if (psel && penable && pwrite && pready
                && paddr[PADDR_W-1] == REG_CHECK_START) begin
                check_start_reg <= pwdata[0];
            end
            if (accept) begin
                position_reg    <= position_next;
                length_high_reg <= length_high_next;
                length_low_reg  <= length_low_next;
                frame_id_reg    <= frame_id_next;
                sum_reg         <= sum_next;
                esc_reg         <= esc_next;
                over_reg        <= over_next;
                event_reg       <= event_next;
                m_valid_reg     <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg <= data_next;
        end
    end

endmodule

[rtl/efr_checker.sv]
// Checker: port-level assertions for the escaped frame receiver, bound to the top level.
`timescale 1ns / 1ps

module efr_checker
    import efr_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic [2:0]         m_tuser,
    input logic               m_tvalid,
    input logic               m_tready
);

    // a held result stays unchanged until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // every input transaction yields a result in the next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("no result after input transaction");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= EV_START)
        else $error("event code out of range");

    // payload byte and frame length only on their own events
    a_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != EV_DATA && m_tuser != EV_OK && m_tuser != EV_BADSUM
        |-> m_tdata[7:0] == 8'd0 && m_tdata[29:23] == 7'd0)
        else $error("payload fields set on a non-frame event");

endmodule

bind escaped_frame_receiver efr_checker u_efr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
